FILE: rtl/dht_pkg.sv
// ----------------------------------------------------------------------------
// dht_pkg
// types and codes shared by the double hashing table modules
// ----------------------------------------------------------------------------
package dht_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] ST_SUCCESS   = 2'd0;
    localparam logic [1:0] ST_FAILURE   = 2'd1;
    localparam logic [1:0] ST_FOUND     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam int KEY_W  = 32;
    localparam int PAY_W  = 64;
    localparam int SIZE_W = 11;
    localparam int SLOT_W = 10;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [PAY_W-1:0]  found_payload;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] m;
    } t_hash_req;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] idx;
        logic [SIZE_W-1:0] step;
    } t_hash_res;

endpackage

FILE: rtl/dht_ram.sv
// ----------------------------------------------------------------------------
// dht_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module dht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/dht_hash.sv
// ----------------------------------------------------------------------------
// dht_hash
// bit-serial divider: key mod m and (key div m) mod m with bit 0 set, one quotient bit a cycle
// ----------------------------------------------------------------------------
module dht_hash (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dht_pkg::t_hash_req i_req,
    output dht_pkg::t_hash_res o_res
);

    localparam int SW = dht_pkg::SIZE_W;
    localparam int KW = dht_pkg::KEY_W;
    localparam int CW = $clog2(KW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [KW-1:0] r_key;
    logic [SW-1:0] r_m;
    logic [SW-1:0] r_rem;
    logic [SW-1:0] r_r2;

    logic [SW:0]   w_t1;
    logic [SW:0]   w_t2;
    logic          w_qb;
    logic          w_ge2;
    logic [SW-1:0] n_rem;
    logic [SW-1:0] n_r2;

    always_comb begin
        w_t1  = {r_rem, r_key[KW-1]};
        w_qb  = (w_t1 >= {1'b0, r_m});
        n_rem = w_qb ? SW'(w_t1 - {1'b0, r_m}) : SW'(w_t1);
        w_t2  = {r_r2, w_qb};
        w_ge2 = (w_t2 >= {1'b0, r_m});
        n_r2  = w_ge2 ? SW'(w_t2 - {1'b0, r_m}) : SW'(w_t2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(KW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_key <= i_req.key;
            r_m   <= i_req.m;
            r_rem <= '0;
            r_r2  <= '0;
        end else if (r_busy) begin
            r_key <= {r_key[KW-2:0], 1'b0};
            r_rem <= n_rem;
            r_r2  <= n_r2;
        end
    end

    assign o_res.done = r_done;
    assign o_res.idx  = r_rem;
    assign o_res.step = r_r2 | SW'(1);

endmodule

FILE: rtl/double_hash_table.sv
// ----------------------------------------------------------------------------
// double_hash_table
// open addressing hash table with double hashing, keys and payloads in ram
// ----------------------------------------------------------------------------
// After reset the block sweeps the key ram, clearing one slot valid bit a
// cycle, and accepts no item until done. Each item is then accepted in the
// idle state, passes the bit-serial divider that forms the start slot and the
// step, takes one probe a cycle (up to m probes, paced by the registered ram
// read), and posts the result once the output register is free. Items decided
// at once (unknown command, full or empty table) skip the divider and probes.
// The next item is taken once the result sits in the output register.
module double_hash_table #(
    parameter int DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dht_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dht_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic [10:0]        i_cfg_data
);

    localparam int SW = dht_pkg::SIZE_W;
    localparam int KW = dht_pkg::KEY_W;
    localparam int PW = dht_pkg::PAY_W;
    localparam int AW = $clog2(DEPTH);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]    r_state;
    logic [AW-1:0] r_clr;
    logic [SW-1:0] r_table_size;
    logic [SW-1:0] r_count;
    logic [SW-1:0] r_m;
    logic [SW-1:0] r_idx;
    logic [SW-1:0] r_step;
    logic [SW-1:0] r_probe;
    logic [1:0]    r_cmd;
    logic [KW-1:0] r_key;
    logic [PW-1:0] r_pay;
    dht_pkg::t_out_item r_res;
    dht_pkg::t_out_item r_out;
    logic          r_out_valid;

    logic [SW-1:0] w_m;
    logic [SW:0]   w_sum;
    logic [SW-1:0] w_next;
    logic          w_accept;

    dht_pkg::t_hash_req w_hreq;
    dht_pkg::t_hash_res w_hres;

    logic          w_k_we;
    logic [AW-1:0] w_k_waddr;
    logic [KW:0]   w_k_wdata;
    logic          w_p_we;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [KW:0]   w_k_rdata;
    logic [PW-1:0] w_p_rdata;
    logic          w_hit_v;
    logic          w_hit_k;

    always_comb begin
        if (r_table_size == '0) begin
            w_m = SW'(1);
        end else if (32'(r_table_size) > DEPTH) begin
            w_m = SW'(DEPTH);
        end else begin
            w_m = r_table_size;
        end
    end

    assign w_accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    assign w_hreq.start = w_accept;
    assign w_hreq.key   = i_in_item.key;
    assign w_hreq.m     = w_m;

    dht_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_hreq),
        .o_res   (w_hres)
    );

    assign w_sum  = {1'b0, r_idx} + {1'b0, r_step};
    assign w_next = (w_sum >= {1'b0, r_m}) ? SW'(w_sum - {1'b0, r_m}) : SW'(w_sum);

    assign w_hit_v = w_k_rdata[KW];
    assign w_hit_k = (w_k_rdata[KW-1:0] == r_key);

    always_comb begin
        w_k_we    = 1'b0;
        w_k_waddr = AW'(r_idx);
        w_k_wdata = {1'b1, r_key};
        w_p_we    = 1'b0;
        w_re      = 1'b0;
        w_raddr   = AW'(r_idx);
        unique case (r_state)
            S_CLEAR: begin
                w_k_we    = 1'b1;
                w_k_waddr = r_clr;
                w_k_wdata = '0;
            end
            S_HASH: begin
                w_re    = w_hres.done;
                w_raddr = AW'(w_hres.idx);
            end
            S_CHECK: begin
                if (r_cmd == dht_pkg::CMD_INSERT) begin
                    if (!w_hit_v) begin
                        w_k_we = 1'b1;
                        w_p_we = 1'b1;
                    end
                end else if (r_cmd == dht_pkg::CMD_DELETE && w_hit_v && w_hit_k) begin
                    w_k_we    = 1'b1;
                    w_k_wdata = '0;
                end
                w_re    = 1'b1;
                w_raddr = AW'(w_next);
            end
            default: begin
            end
        endcase
    end

    dht_ram #(.WIDTH(KW + 1), .DEPTH(DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_k_we),
        .i_waddr (w_k_waddr),
        .i_wdata (w_k_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_k_rdata)
    );

    dht_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (AW'(r_idx)),
        .i_wdata (r_pay),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_p_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= 11'd1024;
        end else if (i_cfg_we) begin
            r_table_size <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd <= i_in_item.cmd;
                        r_key <= i_in_item.key;
                        r_pay <= i_in_item.payload;
                        r_m   <= w_m;
                        r_res <= '{status: (i_in_item.cmd == dht_pkg::CMD_SEARCH) ?
                                           dht_pkg::ST_NOT_FOUND : dht_pkg::ST_FAILURE,
                                   slot: '0, found_payload: '0};
                        priority if (i_in_item.cmd == dht_pkg::CMD_INSERT) begin
                            r_state <= (r_count >= w_m) ? S_FIN : S_HASH;
                        end else if (i_in_item.cmd == dht_pkg::CMD_DELETE ||
                                     i_in_item.cmd == dht_pkg::CMD_SEARCH) begin
                            r_state <= (r_count == '0) ? S_FIN : S_HASH;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_HASH: begin
                    if (w_hres.done) begin
                        r_idx   <= w_hres.idx;
                        r_step  <= w_hres.step;
                        r_probe <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_idx   <= w_next;
                    r_probe <= r_probe + 1'b1;
                    if (r_cmd == dht_pkg::CMD_INSERT && !w_hit_v) begin
                        r_count      <= r_count + 1'b1;
                        r_res.status <= dht_pkg::ST_SUCCESS;
                        r_res.slot   <= dht_pkg::SLOT_W'(r_idx);
                        r_state      <= S_FIN;
                    end else if (r_cmd == dht_pkg::CMD_INSERT && w_hit_k) begin
                        r_state <= S_FIN;
                    end else if (r_cmd != dht_pkg::CMD_INSERT && w_hit_v && w_hit_k) begin
                        r_res.slot <= dht_pkg::SLOT_W'(r_idx);
                        r_state    <= S_FIN;
                        if (r_cmd == dht_pkg::CMD_DELETE) begin
                            r_count      <= r_count - 1'b1;
                            r_res.status <= dht_pkg::ST_SUCCESS;
                        end else begin
                            r_res.status        <= dht_pkg::ST_FOUND;
                            r_res.found_payload <= w_p_rdata;
                        end
                    end else if (r_probe == r_m - 1'b1) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: tb/tb_double_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_hash_table
// drives insert, delete, search and unknown items with random gaps and output
// stalls, predicts answers from a shadow copy of the table, checks each result
// ----------------------------------------------------------------------------
module tb_double_hash_table;

    localparam int DEPTH = 1024;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    dht_pkg::t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    dht_pkg::t_out_item o_out_item;
    logic      i_cfg_we;
    logic [10:0] i_cfg_data;

    double_hash_table #(.DEPTH(DEPTH)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    // shadow table
    logic [10:0] shadow_size;
    logic [31:0] shadow_keys [DEPTH];
    logic [63:0] shadow_pays [DEPTH];
    bit          shadow_valid [DEPTH];
    int unsigned shadow_count;

    dht_pkg::t_out_item expected_answers[$];
    logic [31:0] live_keys[$];
    int          mismatches;
    int          send_gap_pct;
    int          stall_pct;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic dht_pkg::t_out_item predict_answer(dht_pkg::t_in_item it);
        dht_pkg::t_out_item r;
        int unsigned m, idx, step, i;
        r = '0;
        m = 32'(shadow_size);
        if (m == 0) m = 1;
        if (m > DEPTH) m = DEPTH;
        idx = it.key % m;
        step = (it.key / m) % m;
        if (step[0] == 1'b0) step++;
        r.status = dht_pkg::ST_FAILURE;
        if (it.cmd == dht_pkg::CMD_INSERT) begin
            if (shadow_count >= m) return r;
            for (i = 0; i < m; i++) begin
                if (!shadow_valid[idx]) begin
                    shadow_valid[idx] = 1;
                    shadow_keys[idx] = it.key;
                    shadow_pays[idx] = it.payload;
                    shadow_count++;
                    live_keys.push_back(it.key);
                    r.status = dht_pkg::ST_SUCCESS;
                    r.slot = 10'(idx);
                    return r;
                end
                if (shadow_keys[idx] == it.key) return r;
                idx += step;
                if (idx >= m) idx -= m;
            end
            return r;
        end else if (it.cmd == dht_pkg::CMD_DELETE || it.cmd == dht_pkg::CMD_SEARCH) begin
            if (it.cmd == dht_pkg::CMD_SEARCH) r.status = dht_pkg::ST_NOT_FOUND;
            if (shadow_count == 0) return r;
            for (i = 0; i < m; i++) begin
                if (shadow_valid[idx] && shadow_keys[idx] == it.key) begin
                    r.slot = 10'(idx);
                    if (it.cmd == dht_pkg::CMD_DELETE) begin
                        shadow_valid[idx] = 0;
                        shadow_count--;
                        r.status = dht_pkg::ST_SUCCESS;
                    end else begin
                        r.status = dht_pkg::ST_FOUND;
                        r.found_payload = shadow_pays[idx];
                    end
                    return r;
                end
                idx += step;
                if (idx >= m) idx -= m;
            end
        end
        return r;
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [31:0] key,
                             input logic [63:0] pay);
        dht_pkg::t_in_item it;
        it.cmd = cmd;
        it.key = key;
        it.payload = pay;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        expected_answers.push_back(predict_answer(it));
    endtask

    // results are taken at the edge where valid and ready are both high
    always @(posedge i_clk) begin
        dht_pkg::t_out_item e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_answers.size() == 0) begin
                $display("%0t unexpected result %h", $time, o_out_item);
                mismatches++;
            end else begin
                e = expected_answers.pop_front();
                if (o_out_item.status !== e.status) begin
                    $display("%0t status exp %0d got %0d", $time, e.status,
                             o_out_item.status);
                    mismatches++;
                end
                if (o_out_item.slot !== e.slot) begin
                    $display("%0t slot exp %0d got %0d", $time, e.slot, o_out_item.slot);
                    mismatches++;
                end
                if (o_out_item.found_payload !== e.found_payload) begin
                    $display("%0t payload exp %h got %h", $time, e.found_payload,
                             o_out_item.found_payload);
                    mismatches++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_answers.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [10:0] sz);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= sz;
        @(posedge i_clk);
        shadow_size = sz;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        if (live_keys.size() != 0 && $urandom_range(1))
            return live_keys[$urandom_range(live_keys.size() - 1)];
        if ($urandom_range(3) == 0) return $urandom;
        return $urandom_range(63);
    endfunction

    task automatic test_directed();
        set_size(11'd1024);
        send_item(dht_pkg::CMD_SEARCH, 32'd0, 64'd0);
        send_item(dht_pkg::CMD_DELETE, 32'd0, 64'd0);
        send_item(dht_pkg::CMD_INSERT, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(dht_pkg::CMD_INSERT, 32'hFFFF_FFFF, 64'h0);
        send_item(dht_pkg::CMD_INSERT, 32'd0, 64'd5);
        send_item(dht_pkg::CMD_SEARCH, 32'd0, 64'd0);
        send_item(dht_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 64'd0);
        send_item(dht_pkg::CMD_SEARCH, 32'd1024, 64'd0);
        send_item(CMD_UNKNOWN, 32'd7, 64'd7);
        send_item(dht_pkg::CMD_DELETE, 32'hFFFF_FFFF, 64'd0);
        send_item(dht_pkg::CMD_DELETE, 32'hFFFF_FFFF, 64'd0);
        set_size(11'd0);
        send_item(dht_pkg::CMD_INSERT, 32'd9, 64'd1);
        send_item(dht_pkg::CMD_SEARCH, 32'd0, 64'd0);
        set_size(11'd2047);
        send_item(dht_pkg::CMD_SEARCH, 32'd0, 64'd0);
        set_size(11'd4);
        send_item(dht_pkg::CMD_INSERT, 32'd1, 64'd1);
        send_item(dht_pkg::CMD_INSERT, 32'd2, 64'd2);
        send_item(dht_pkg::CMD_INSERT, 32'd3, 64'd3);
        send_item(dht_pkg::CMD_INSERT, 32'd4, 64'd4);
        send_item(dht_pkg::CMD_INSERT, 32'd5, 64'd5);
        send_item(dht_pkg::CMD_SEARCH, 32'd3, 64'd0);
    endtask

    task automatic test_random(input int n, input logic [10:0] sz);
        logic [1:0] c;
        set_size(sz);
        for (int i = 0; i < n; i++) begin
            c = ($urandom_range(15) == 0) ? CMD_UNKNOWN : 2'($urandom_range(2));
            send_item(c, pick_key(), {$urandom, $urandom});
            if (i == n / 2) drain();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        mismatches = 0;
        shadow_size = 11'd1024;
        shadow_count = 0;
        for (int i = 0; i < DEPTH; i++) shadow_valid[i] = 0;
        send_gap_pct = 10;
        stall_pct = 62;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(250, 11'd7);
        test_random(250, 11'd1);
        send_gap_pct = 62;
        stall_pct = 10;
        test_random(250, 11'd64);
        test_random(250, 11'd2);
        send_gap_pct = 0;
        stall_pct = 0;
        test_random(250, 11'd1024);
        test_random(250, 11'd33);
        drain();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: files.f
rtl/dht_pkg.sv
rtl/dht_ram.sv
rtl/dht_hash.sv
rtl/double_hash_table.sv
tb/tb_double_hash_table.sv
